FILE: hdl/smr_pkg.sv
// ----------------------------------------------------------------------------
// smr_pkg
// Shared widths, fixed-point constants and register indexes for the seagrass
// mortality pipeline.
// ----------------------------------------------------------------------------
package smr_pkg;

  // value width and fraction bits of the unsigned fixed-point format
  localparam int QW        = 48;
  localparam int FRAC_BITS = 32;
  localparam int HW        = QW / 2;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP  = 2;
  localparam int DIV_A_W   = 64;

  localparam int LAT_MUL   = 2;
  localparam int LAT_DIV   = 1 + QW / DIV_STEP;

  localparam logic [QW-1:0] MAX48 = {QW{1'b1}};
  localparam logic [32:0]   ONE   = 33'(64'd1 << FRAC_BITS);

  // shear mortality cap, two per day expressed per second
  localparam logic [QW-1:0] CAP = QW'((64'd2 << FRAC_BITS) / 64'd86400);

  localparam logic [QW-1:0] TAU_CRIT_RST  = QW'(64'd1 << FRAC_BITS);
  localparam logic [63:0]   EF_FULL       = 64'd43200 << FRAC_BITS;
  localparam logic [QW-1:0] TAU_EFOLD_RST = (EF_FULL > 64'(MAX48)) ? MAX48 : EF_FULL[QW-1:0];

  typedef enum logic [2:0] {
    REG_LEAF_MORT = 3'd0,
    REG_ROOT_MORT = 3'd1,
    REG_SEED      = 3'd2,
    REG_ROOT_FRAC = 3'd3,
    REG_QUAD_MORT = 3'd4,
    REG_TAU_CRIT  = 3'd5,
    REG_TAU_EFOLD = 3'd6
  } reg_idx_t;

endpackage

FILE: hdl/smr_delay.sv
// ----------------------------------------------------------------------------
// smr_delay
// Enable-gated shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module smr_delay import smr_pkg::*; #(
  parameter int W = QW,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign dout = sr[N-1];

endmodule

FILE: hdl/smr_mul.sv
// ----------------------------------------------------------------------------
// smr_mul
// Two-stage fixed-point multiplier: half-width partial products, then sum,
// shift by the fraction bits and saturate.
// ----------------------------------------------------------------------------
module smr_mul import smr_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] a,
  input  logic [QW-1:0] b,
  output logic [QW-1:0] p
);

  logic [QW-1:0]   p0, p1, p2, p3;
  logic [2*QW-1:0] full;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= QW'(a[HW-1:0])  * QW'(b[HW-1:0]);
      p1 <= QW'(a[HW-1:0])  * QW'(b[QW-1:HW]);
      p2 <= QW'(a[QW-1:HW]) * QW'(b[HW-1:0]);
      p3 <= QW'(a[QW-1:HW]) * QW'(b[QW-1:HW]);
    end
  end

  always_comb begin
    full = {{QW{1'b0}}, p0}
         + ({{QW{1'b0}}, p1} << HW)
         + ({{QW{1'b0}}, p2} << HW)
         + ({{QW{1'b0}}, p3} << QW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (|full[2*QW-1:FRAC_BITS+QW]) ? MAX48 : full[FRAC_BITS +: QW];
    end
  end

endmodule

FILE: hdl/smr_div.sv
// ----------------------------------------------------------------------------
// smr_div
// Pipelined restoring divider giving floor(a * 2^frac / b), saturated,
// two (DIV_STEP) quotient bits per stage.
// ----------------------------------------------------------------------------
module smr_div import smr_pkg::*; #(
  parameter int A_W = DIV_A_W
) (
  input  logic           clk,
  input  logic           en,
  input  logic [A_W-1:0] a,
  input  logic [QW-1:0]  b,
  output logic [QW-1:0]  q
);

  localparam int STEPS = QW / DIV_STEP;
  localparam int SH    = QW - FRAC_BITS;
  localparam int D_W   = A_W + FRAC_BITS;

  logic [QW-1:0] rem_q [0:STEPS];
  logic [QW-1:0] low_q [0:STEPS];
  logic [QW-1:0] quo_q [0:STEPS];
  logic [QW-1:0] b_q   [0:STEPS];
  logic          ovf_q [0:STEPS];

  logic [D_W-1:0] dvd;

  assign dvd = {a, {FRAC_BITS{1'b0}}};

  // quotient wider than QW bits, or a zero divisor, saturates
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= QW'(dvd >> QW);
      low_q[0] <= dvd[QW-1:0];
      quo_q[0] <= '0;
      b_q[0]   <= b;
      ovf_q[0] <= ({{QW{1'b0}}, a} >= ({{A_W{1'b0}}, b} << SH));
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_stage
    logic [QW-1:0] rem_n, low_n, quo_n;

    always_comb begin
      logic [QW:0] trial;
      rem_n = rem_q[j];
      low_n = low_q[j];
      quo_n = quo_q[j];
      for (int t = 0; t < DIV_STEP; t++) begin
        trial = {rem_n, low_n[QW-1]};
        low_n = {low_n[QW-2:0], 1'b0};
        if (trial >= {1'b0, b_q[j]}) begin
          trial = trial - {1'b0, b_q[j]};
          quo_n = {quo_n[QW-2:0], 1'b1};
        end else begin
          quo_n = {quo_n[QW-2:0], 1'b0};
        end
        rem_n = trial[QW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j+1] <= rem_n;
        low_q[j+1] <= low_n;
        quo_q[j+1] <= quo_n;
        b_q[j+1]   <= b_q[j];
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  assign q = ovf_q[STEPS] ? MAX48 : quo_q[STEPS];

endmodule

FILE: hdl/seagrass_mortality_rates.sv
// ----------------------------------------------------------------------------
// seagrass_mortality_rates
// Per-cell seagrass leaf, root, detritus and shear mortality rates in
// unsigned fixed point, as a deep pipeline with a two-beat output queue.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle when not stalled by a full output queue, set
//   by the fully pipelined multipliers and the two pipelined dividers (shear
//   ratio, detritus gain)
// reset: rst clears the pipeline valid bits and the output queue and returns
//   the registers to their defaults; the derived seed split and 1/efold come
//   from free-running units that are not reset themselves
module seagrass_mortality_rates import smr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  // input beats
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // leaf_biomass, root_biomass, friction_velocity, temp_factor, sed_thickness
  input  logic [239:0]   s_axis_tdata,
  // result beats
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // leaf_loss, root_loss, detritus_gain, shear_loss_daily
  output logic [191:0]   m_axis_tdata,
  // register writes
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [QW-1:0]  cfg_data
);

  // stage numbers, counted in registers after the input stage
  localparam int S_L    = LAT_MUL + 1;
  localparam int S_DIFF = S_L + 1;
  localparam int S_MB   = S_L + LAT_MUL;
  localparam int S_MC   = S_MB + LAT_MUL;
  localparam int S_ML   = S_MC + 1;
  localparam int S_RAT  = S_DIFF + LAT_DIV;
  localparam int S_SR   = S_RAT + LAT_MUL;
  localparam int S_S    = S_SR + 1;
  localparam int S_SAB  = S_S + LAT_MUL;
  localparam int S_SUM  = S_SAB + 1;
  localparam int S_OUT  = S_SUM + LAT_DIV;

  // configuration registers
  logic [QW-1:0] leaf_mort_rate, root_mort_rate, seed_biomass, quad_mort_rate;
  logic [QW-1:0] tau_critical, tau_efold;
  logic [32:0]   root_fraction;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_mort_rate <= '0;
      root_mort_rate <= '0;
      seed_biomass   <= '0;
      root_fraction  <= '0;
      quad_mort_rate <= '0;
      tau_critical   <= TAU_CRIT_RST;
      tau_efold      <= TAU_EFOLD_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_LEAF_MORT: leaf_mort_rate <= cfg_data;
        REG_ROOT_MORT: root_mort_rate <= cfg_data;
        REG_SEED:      seed_biomass   <= cfg_data;
        REG_ROOT_FRAC: root_fraction  <= cfg_data[32:0];
        REG_QUAD_MORT: quad_mort_rate <= cfg_data;
        REG_TAU_CRIT:  tau_critical   <= cfg_data;
        REG_TAU_EFOLD: tau_efold      <= cfg_data;
        default: ;
      endcase
    end
  end

  // register-only terms, free running: seed split and 1/efold
  logic [32:0]   rf, rf_inv;
  logic [QW-1:0] leaf_seed, root_seed, inv_efold;

  assign rf     = (root_fraction > ONE) ? ONE : root_fraction;
  assign rf_inv = ONE - rf;

  smr_mul u_mul_ls (.clk, .en(1'b1), .a(seed_biomass), .b(QW'(rf_inv)), .p(leaf_seed));
  smr_mul u_mul_rs (.clk, .en(1'b1), .a(seed_biomass), .b(QW'(rf)),     .p(root_seed));
  smr_div u_div_inv (.clk, .en(1'b1), .a(DIV_A_W'(ONE)), .b(tau_efold), .q(inv_efold));

  // pipeline advance: stall only when a result is ready and the queue is full
  logic           en;
  logic [S_OUT:0] v;
  logic [1:0]     cnt;

  assign en            = !v[S_OUT] || (cnt != 2'd2);
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[S_OUT-1:0], s_axis_tvalid};
    end
  end

  // stage 0: input beat
  logic [QW-1:0] leaf0, root0, u0, tf0, dz0;

  always_ff @(posedge clk) begin
    if (en) begin
      leaf0 <= s_axis_tdata[47:0];
      root0 <= s_axis_tdata[95:48];
      u0    <= s_axis_tdata[143:96];
      tf0   <= s_axis_tdata[191:144];
      dz0   <= s_axis_tdata[239:192];
    end
  end

  // squared velocity and temperature-scaled linear rates
  logic [QW-1:0] uu2, ltf2, rtf2, leaf2, root2;

  smr_mul u_mul_uu  (.clk, .en, .a(u0),             .b(u0),  .p(uu2));
  smr_mul u_mul_ltf (.clk, .en, .a(leaf_mort_rate), .b(tf0), .p(ltf2));
  smr_mul u_mul_rtf (.clk, .en, .a(root_mort_rate), .b(tf0), .p(rtf2));

  smr_delay #(.W(2*QW), .N(LAT_MUL)) u_dly_bio (
    .clk, .en, .din({root0, leaf0}), .dout({root2, leaf2})
  );

  // biomass above seed reserve, shear stress
  logic [QW-1:0] lb3, rb3, tau3, ltf3, rtf3;
  logic [57:0]   tau_full;

  assign tau_full = 58'(uu2) * 58'd1000;

  always_ff @(posedge clk) begin
    if (en) begin
      lb3  <= (leaf2 > leaf_seed) ? leaf2 - leaf_seed : '0;
      rb3  <= (root2 > root_seed) ? root2 - root_seed : '0;
      tau3 <= (|tau_full[57:QW]) ? MAX48 : tau_full[QW-1:0];
      ltf3 <= ltf2;
      rtf3 <= rtf2;
    end
  end

  // excess shear over critical
  logic          gt4;
  logic [QW-1:0] diff4;

  always_ff @(posedge clk) begin
    if (en) begin
      gt4   <= tau3 > tau_critical;
      diff4 <= (tau3 > tau_critical) ? tau3 - tau_critical : '0;
    end
  end

  // linear and quadratic mortality
  logic [QW-1:0] lin5, qa5, mr5, lb5, quad7, lin7;

  smr_mul u_mul_lin (.clk, .en, .a(ltf3),           .b(lb3), .p(lin5));
  smr_mul u_mul_qa  (.clk, .en, .a(quad_mort_rate), .b(lb3), .p(qa5));
  smr_mul u_mul_mr  (.clk, .en, .a(rtf3),           .b(rb3), .p(mr5));

  smr_delay #(.W(QW), .N(S_MB - S_L)) u_dly_lb5 (.clk, .en, .din(lb3), .dout(lb5));

  smr_mul u_mul_quad (.clk, .en, .a(qa5), .b(lb5), .p(quad7));

  smr_delay #(.W(QW), .N(S_MC - S_MB)) u_dly_lin (.clk, .en, .din(lin5), .dout(lin7));

  logic [QW-1:0] ml8;
  logic [QW:0]   ml_sum;

  assign ml_sum = {1'b0, lin7} + {1'b0, quad7};

  always_ff @(posedge clk) begin
    if (en) begin
      ml8 <= ml_sum[QW] ? MAX48 : ml_sum[QW-1:0];
    end
  end

  // shear mortality rate: ratio, times 1/efold, capped
  logic [QW-1:0] ratio, sraw, s32;
  logic          gt31;

  smr_div u_div_ratio (.clk, .en, .a(DIV_A_W'(diff4)), .b(tau_critical), .q(ratio));
  smr_mul u_mul_s     (.clk, .en, .a(ratio), .b(inv_efold), .p(sraw));

  smr_delay #(.W(1), .N(S_SR - S_DIFF)) u_dly_gt (.clk, .en, .din(gt4), .dout(gt31));

  always_ff @(posedge clk) begin
    if (en) begin
      s32 <= gt31 ? ((sraw > CAP) ? CAP : sraw) : '0;
    end
  end

  logic [QW-1:0] lb32, rb32, sa34, sb34, ml34, mr34, dz35;

  smr_delay #(.W(2*QW), .N(S_S - S_L)) u_dly_lr (
    .clk, .en, .din({rb3, lb3}), .dout({rb32, lb32})
  );

  smr_mul u_mul_sa (.clk, .en, .a(s32), .b(lb32), .p(sa34));
  smr_mul u_mul_sb (.clk, .en, .a(s32), .b(rb32), .p(sb34));

  smr_delay #(.W(QW), .N(S_SAB - S_MB)) u_dly_mr (.clk, .en, .din(mr5), .dout(mr34));
  smr_delay #(.W(QW), .N(S_SAB - S_ML)) u_dly_ml (.clk, .en, .din(ml8), .dout(ml34));
  smr_delay #(.W(QW), .N(S_SUM))        u_dly_dz (.clk, .en, .din(dz0), .dout(dz35));

  // output sums, daily shear and detritus numerator
  logic [QW:0]    ll_sum, rl_sum;
  logic [QW+1:0]  tot_sum;
  logic [QW+16:0] sh_full;
  logic [QW-1:0]  ll35, rl35, sh35;
  logic [63:0]    num35;

  assign ll_sum  = {1'b0, ml34} + {1'b0, sa34};
  assign rl_sum  = {1'b0, mr34} + {1'b0, sb34};
  assign tot_sum = {1'b0, ll_sum} + {1'b0, rl_sum};
  assign sh_full = (QW+17)'(sa34) * (QW+17)'(86400);

  always_ff @(posedge clk) begin
    if (en) begin
      ll35  <= ll_sum[QW] ? MAX48 : ll_sum[QW-1:0];
      rl35  <= rl_sum[QW] ? MAX48 : rl_sum[QW-1:0];
      sh35  <= (|sh_full[QW+16:QW]) ? MAX48 : sh_full[QW-1:0];
      // unsaturated sum scaled by 1000, at most 60 bits
      num35 <= 64'(tot_sum) * 64'd1000;
    end
  end

  logic [QW-1:0] det60, ll60, rl60, sh60;

  smr_div u_div_det (.clk, .en, .a(num35), .b(dz35), .q(det60));

  smr_delay #(.W(3*QW), .N(S_OUT - S_SUM)) u_dly_out (
    .clk, .en, .din({sh35, rl35, ll35}), .dout({sh60, rl60, ll60})
  );

  // two-beat output queue
  logic [191:0] res_q [0:1];
  logic         wr_ptr, rd_ptr, push, pop;

  assign push = v[S_OUT] && en;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      res_q[wr_ptr] <= {sh60, det60, rl60, ll60};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = res_q[rd_ptr];

  // checks
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v[0])
    else $error("accepted beat did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !en |=> v[S_OUT])
    else $error("stalled result left the last stage");

  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !push || pop)
    else $error("output queue overrun");

endmodule
